### src/prefix_directory_key_search_top_macros.svh
// assertion macros for the prefix directory key search block
// used by the checker bound to the top level, no other dependencies
`ifndef PREFIX_DIRECTORY_KEY_SEARCH_TOP_MACROS_SVH
`define PREFIX_DIRECTORY_KEY_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define PDKS_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("pdks check failed");

// next-cycle implication
`define PDKS_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("pdks check failed");

`endif

### src/pdks_pkg.sv
// shared types and constants for the prefix directory key search block
// no dependencies
`timescale 1ns / 1ps

package pdks_pkg;

   localparam int KEY_W              = 32;
   localparam int POS_W              = 12;
   localparam int DEFAULT_PREFIX_BITS = 16;
   localparam int DEFAULT_MAX_KEYS    = 4096;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_FINISH = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_ORDER     = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       append;
      logic       fin_init;
      logic       fin_write;
      logic       fin_done;
      logic       dir_hi;
      logic       lo_load;
      logic       hi_load;
      logic       ptr_inc;
      logic       res_set;
      logic       res_found;
      status_type res_status;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       dir_ready;
      logic       full;
      logic       order_err;
      logic       fin_more;
      logic       fin_last;
      logic       scan_end;
      logic       key_hit;
   } stat_type;

endpackage

### src/prefix_directory_key_search_top.sv
// top level of the prefix directory key search block
// depends on pdks_pkg, pdks_ctrl, pdks_datapath and pdks_ram
//
// channel   dir   handshake               payload
// req       in    req_tvalid/req_tready   tuser opcode, tdata key
// rsp       out   rsp_tvalid/rsp_tready   tdata found and position, tuser status
//
// one request at a time; clear and append pass through the execute state to a result
// finish writes one directory entry per cycle while no key is to be walked, and
// reads the key store once for every key walked
// query reads its bucket bounds from the directory, then scans the bucket, key store read bound
// the result register frees intake: a new request is taken while a result waits
// reset clears control state only; the stores are not swept
`timescale 1ns / 1ps

module prefix_directory_key_search_top #(
   parameter int PREFIX_BITS = pdks_pkg::DEFAULT_PREFIX_BITS,
   parameter int MAX_KEYS    = pdks_pkg::DEFAULT_MAX_KEYS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[31:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // found[0], position[12:1], zero[15:13]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   pdks_pkg::cmd_type  cmd;
   pdks_pkg::stat_type stat;
   logic                       out_found;
   logic [pdks_pkg::POS_W-1:0] out_position;

   pdks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pdks_datapath #(
      .PREFIX_BITS (PREFIX_BITS),
      .MAX_KEYS    (MAX_KEYS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_opcode    (req_tuser),
      .in_key       (req_tdata),
      .cmd          (cmd),
      .stat         (stat),
      .out_found    (out_found),
      .out_position (out_position),
      .out_status   (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, out_position, out_found};

endmodule

### src/pdks_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies beyond the package defaults
`timescale 1ns / 1ps

module pdks_ram #(
   parameter int WIDTH = pdks_pkg::KEY_W,
   parameter int DEPTH = pdks_pkg::DEFAULT_MAX_KEYS,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pdks_datapath.sv
// datapath: key store, bucket directory, pointers, result and output registers
// depends on pdks_pkg and pdks_ram
`timescale 1ns / 1ps

module pdks_datapath #(
   parameter int PREFIX_BITS = pdks_pkg::DEFAULT_PREFIX_BITS,
   parameter int MAX_KEYS    = pdks_pkg::DEFAULT_MAX_KEYS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                in_opcode,
   input  logic [pdks_pkg::KEY_W-1:0] in_key,
   input  pdks_pkg::cmd_type         cmd,
   output pdks_pkg::stat_type        stat,
   output logic                      out_found,
   output logic [pdks_pkg::POS_W-1:0] out_position,
   output logic [1:0]                out_status
);

   localparam int KW       = pdks_pkg::KEY_W;
   localparam int PW       = pdks_pkg::POS_W;
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int KAW      = $clog2(MAX_KEYS);
   localparam int DIR_AW   = PREFIX_BITS + 1;
   localparam int DIR_DEPTH = (2 ** PREFIX_BITS) + 1;
   localparam logic [DIR_AW-1:0] LAST_P = DIR_AW'(2 ** PREFIX_BITS);
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_KEYS);

   pdks_pkg::opcode_type op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KW-1:0]     prev_ff, prev_in;
   logic              empty_ff, empty_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [DIR_AW-1:0] p_ff, p_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic              res_found_ff, res_found_in;
   logic [PW-1:0]     res_pos_ff, res_pos_in;
   pdks_pkg::status_type res_status_ff, res_status_in;
   logic              out_found_ff, out_found_in;
   logic [PW-1:0]     out_pos_ff, out_pos_in;
   logic [1:0]        out_status_ff, out_status_in;

   logic [KW-1:0]     key_rd;
   logic [CNT_W-1:0]  dir_rd;
   logic [DIR_AW-1:0] h_ext;
   logic [DIR_AW-1:0] dir_raddr;

   assign h_ext     = {1'b0, key_ff[KW-1 -: PREFIX_BITS]};
   assign dir_raddr = cmd.dir_hi ? (h_ext + DIR_AW'(1)) : h_ext;

   pdks_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[KAW-1:0]),
      .wr_data (key_ff),
      .rd_addr (ptr_ff[KAW-1:0]),
      .rd_data (key_rd)
   );

   pdks_ram #(.WIDTH(CNT_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
      .clock   (clock),
      .wr_en   (cmd.fin_write),
      .wr_addr (p_ff),
      .wr_data (ptr_ff),
      .rd_addr (dir_raddr),
      .rd_data (dir_rd)
   );

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      prev_in       = prev_ff;
      empty_in      = empty_ff;
      ready_in      = ready_ff;
      ptr_in        = ptr_ff;
      p_in          = p_ff;
      hi_in         = hi_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      out_found_in  = out_found_ff;
      out_pos_in    = out_pos_ff;
      out_status_in = out_status_ff;

      if (cmd.load) begin
         op_in  = pdks_pkg::opcode_type'(in_opcode);
         key_in = in_key;
      end
      if (cmd.clear) begin
         count_in = '0;
         prev_in  = '0;
         empty_in = 1'b1;
         ready_in = 1'b0;
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
         prev_in  = key_ff;
         empty_in = 1'b0;
         ready_in = 1'b0;
      end
      if (cmd.fin_init) begin
         ptr_in = '0;
         p_in   = '0;
      end
      if (cmd.fin_write) begin
         p_in = p_ff + DIR_AW'(1);
      end
      if (cmd.fin_done) begin
         ready_in = 1'b1;
      end
      if (cmd.lo_load) begin
         ptr_in = dir_rd;
      end
      if (cmd.hi_load) begin
         hi_in = (dir_rd < count_ff) ? dir_rd : count_ff;
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.res_set) begin
         res_found_in  = cmd.res_found;
         res_pos_in    = cmd.res_found ? PW'(ptr_ff) : '0;
         res_status_in = cmd.res_status;
      end
      if (cmd.out_load) begin
         out_found_in  = res_found_ff;
         out_pos_in    = res_pos_ff;
         out_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= '0;
         empty_ff <= 1'b1;
         ready_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         empty_ff <= empty_in;
         ready_ff <= ready_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      p_ff          <= p_in;
      hi_ff         <= hi_in;
      res_found_ff  <= res_found_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
      out_found_ff  <= out_found_in;
      out_pos_ff    <= out_pos_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      stat.op        = op_ff;
      stat.dir_ready = ready_ff;
      stat.full      = (count_ff >= MAX_CNT);
      stat.order_err = !empty_ff && (key_ff < prev_ff);
      stat.fin_more  = (ptr_ff < count_ff)
                       && ({1'b0, key_rd[KW-1 -: PREFIX_BITS]} < p_ff);
      stat.fin_last  = (p_ff == LAST_P);
      stat.scan_end  = (ptr_ff >= hi_ff);
      stat.key_hit   = (key_rd == key_ff);
   end

   assign out_found    = out_found_ff;
   assign out_position = out_pos_ff;
   assign out_status   = out_status_ff;

endmodule

### src/pdks_ctrl.sv
// controller state machine: request intake, command sequencing, response valid
// depends on pdks_pkg
`timescale 1ns / 1ps

module pdks_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  pdks_pkg::stat_type stat,
   output pdks_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_F_WAIT = 9'b000000100,
      S_F_CMP  = 9'b000001000,
      S_Q_HI   = 9'b000010000,
      S_Q_BND  = 9'b000100000,
      S_Q_WAIT = 9'b001000000,
      S_Q_CMP  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_status = pdks_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.op)
               pdks_pkg::OP_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.res_set = 1'b1;
                  state_in    = S_RESP;
               end
               pdks_pkg::OP_APPEND: begin
                  cmd.res_set = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = pdks_pkg::ST_FULL;
                  end else if (stat.order_err) begin
                     cmd.res_status = pdks_pkg::ST_ORDER;
                  end else begin
                     cmd.append = 1'b1;
                  end
                  state_in = S_RESP;
               end
               pdks_pkg::OP_FINISH: begin
                  cmd.fin_init = 1'b1;
                  state_in     = S_F_WAIT;
               end
               pdks_pkg::OP_QUERY: begin
                  if (stat.dir_ready) begin
                     state_in = S_Q_HI;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = pdks_pkg::ST_NOT_READY;
                     state_in       = S_RESP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_F_WAIT: begin
            state_in = S_F_CMP;
         end
         S_F_CMP: begin
            if (stat.fin_more) begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_F_WAIT;
            end else begin
               cmd.fin_write = 1'b1;
               if (stat.fin_last) begin
                  cmd.fin_done = 1'b1;
                  cmd.res_set  = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end
         S_Q_HI: begin
            cmd.dir_hi  = 1'b1;
            cmd.lo_load = 1'b1;
            state_in    = S_Q_BND;
         end
         S_Q_BND: begin
            cmd.hi_load = 1'b1;
            state_in    = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            state_in = S_Q_CMP;
         end
         S_Q_CMP: begin
            if (stat.scan_end) begin
               cmd.res_set = 1'b1;
               state_in    = S_RESP;
            end else if (stat.key_hit) begin
               cmd.res_set   = 1'b1;
               cmd.res_found = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_Q_WAIT;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### src/pdks_checker.sv
// port level checks for the prefix directory key search block
// depends on pdks_pkg and the macros header; bound to the top level
`timescale 1ns / 1ps
`include "prefix_directory_key_search_top_macros.svh"

module pdks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `PDKS_ASSERT_NEXT(a_reset_no_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `PDKS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `PDKS_ASSERT_SAME(a_found_ok, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tuser == pdks_pkg::ST_OK)
   `PDKS_ASSERT_SAME(a_miss_zero_pos, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[12:1] == 12'd0)
   `PDKS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind prefix_directory_key_search_top pdks_checker u_pdks_checker (.*);
